[rtl/prq_pkg.sv]
// Package with the item types, codes and shared constants of the priority queue.
`timescale 1ns / 1ps
package prq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_W         = 8;
    localparam int PRI_W        = 8;
    localparam int OCC_W        = 5;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQ_OK    = 2'd0;
    localparam logic [1:0] ST_DEQ_OK    = 2'd1;
    localparam logic [1:0] ST_DEQ_EMPTY = 2'd2;
    localparam logic [1:0] ST_ENQ_FULL  = 2'd3;

    typedef struct packed {
        logic             func;
        logic [ID_W-1:0]  item_id;
        logic [PRI_W-1:0] item_priority;
    } prq_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  out_id;
        logic [PRI_W-1:0] out_priority;
        logic [OCC_W-1:0] occupancy;
    } prq_out_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } prq_cmd_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [ID_W-1:0]  head_id;
        logic [PRI_W-1:0] head_priority;
        logic [OCC_W-1:0] occupancy;
    } prq_stat_t;

    typedef enum logic {
        OUT_IDLE,
        OUT_HOLD
    } prq_state_t;

endpackage

[rtl/prq_datapath.sv]
// Sorted shift-register array of queue entries with per-slot priority compares.
`timescale 1ns / 1ps
module prq_datapath
    import prq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  prq_cmd_t  cmd,
    input  prq_in_t   in_data,
    output prq_stat_t stat
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [ID_W-1:0]  slot_id_reg       [CAPACITY];
    logic [ID_W-1:0]  slot_id_next      [CAPACITY];
    logic [PRI_W-1:0] slot_priority_reg [CAPACITY];
    logic [PRI_W-1:0] slot_priority_next[CAPACITY];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    // ge[i]: slot i holds an entry that stays ahead of the new one.
    logic [CAPACITY-1:0] ge;
    logic [CAPACITY-1:0] ge_above;
    logic [ID_W-1:0]     id_above  [CAPACITY];
    logic [PRI_W-1:0]    pri_above [CAPACITY];
    logic [ID_W-1:0]     id_below  [CAPACITY];
    logic [PRI_W-1:0]    pri_below [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_slot
            assign ge[g] = (CW'(g) < count_reg) &&
                           (slot_priority_reg[g] >= in_data.item_priority);

            if (g == 0) begin : g_first
                assign ge_above[g]  = 1'b1;
                assign id_above[g]  = in_data.item_id;
                assign pri_above[g] = in_data.item_priority;
            end
            else begin : g_rest
                assign ge_above[g]  = ge[g-1];
                assign id_above[g]  = slot_id_reg[g-1];
                assign pri_above[g] = slot_priority_reg[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign id_below[g]  = slot_id_reg[g];
                assign pri_below[g] = slot_priority_reg[g];
            end
            else begin : g_inner
                assign id_below[g]  = slot_id_reg[g+1];
                assign pri_below[g] = slot_priority_reg[g+1];
            end

            always_comb
            begin
                slot_id_next[g]       = slot_id_reg[g];
                slot_priority_next[g] = slot_priority_reg[g];
                if (cmd.enq && !ge[g])
                begin
                    if (ge_above[g])
                    begin
                        slot_id_next[g]       = in_data.item_id;
                        slot_priority_next[g] = in_data.item_priority;
                    end
                    else
                    begin
                        slot_id_next[g]       = id_above[g];
                        slot_priority_next[g] = pri_above[g];
                    end
                end
                else if (cmd.deq)
                begin
                    slot_id_next[g]       = id_below[g];
                    slot_priority_next[g] = pri_below[g];
                end
            end

            always_ff @(posedge clk)
            begin
                slot_id_reg[g]       <= slot_id_next[g];
                slot_priority_reg[g] <= slot_priority_next[g];
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // The count register already holds the occupancy after the last accepted item.
    assign stat.empty         = (count_reg == '0);
    assign stat.full          = (count_reg == CW'(CAPACITY));
    assign stat.head_id       = slot_id_reg[0];
    assign stat.head_priority = slot_priority_reg[0];
    assign stat.occupancy     = OCC_W'(count_reg);

endmodule

[rtl/prq_ctrl.sv]
// Controller: handshake state machine, command decode and result register.
`timescale 1ns / 1ps
module prq_ctrl
    import prq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      func,
    input  prq_stat_t stat,
    output prq_cmd_t  cmd,
    output logic      out_valid,
    input  logic      out_ready,
    output prq_out_t  out_data
);

    prq_state_t state_reg;
    prq_state_t state_next;
    prq_out_t   out_reg;
    prq_out_t   out_next;
    logic       fire;

    always_comb
    begin
        in_ready   = (state_reg == OUT_IDLE) || out_ready;
        fire       = in_valid && in_ready;
        cmd.enq    = fire && (func == FUNC_ENQ) && !stat.full;
        cmd.deq    = fire && (func == FUNC_DEQ) && !stat.empty;
        state_next = state_reg;
        out_next   = out_reg;

        case (state_reg)
            OUT_IDLE:
            begin
                if (fire)
                begin
                    state_next = OUT_HOLD;
                end
            end
            OUT_HOLD:
            begin
                if (!fire && out_ready)
                begin
                    state_next = OUT_IDLE;
                end
            end
            default:
            begin
                state_next = OUT_IDLE;
            end
        endcase

        if (fire)
        begin
            out_next.out_id       = '0;
            out_next.out_priority = '0;
            out_next.occupancy    = '0;
            if (func == FUNC_ENQ)
            begin
                out_next.status = stat.full ? ST_ENQ_FULL : ST_ENQ_OK;
            end
            else if (stat.empty)
            begin
                out_next.status = ST_DEQ_EMPTY;
            end
            else
            begin
                out_next.status       = ST_DEQ_OK;
                out_next.out_id       = stat.head_id;
                out_next.out_priority = stat.head_priority;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= OUT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // The fill count changes only when a new result is loaded, so while a
    // result is held it still shows the occupancy after that item.
    always_comb
    begin
        out_data           = out_reg;
        out_data.occupancy = stat.occupancy;
    end

    assign out_valid = (state_reg == OUT_HOLD);

endmodule

[rtl/priority_ready_queue_top.sv]
// Top level of the priority queue: controller and sorted entry array.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_ready   in_data  (prq_in_t)
//   result    out        out_valid / out_ready out_data (prq_out_t)
//
// Each item is accepted at a clock edge; the sorted slot array shifts at that
// same edge, and its result is loaded into the result register at that edge
// too. The parallel priority compare across all slots finds the insert point
// in a single step.
// Reset clears the fill count and the result handshake; slot contents are
// not reset and are only read below the fill count. A new item is accepted
// while the previous result is being taken; if the result waits unaccepted,
// in_ready drops until out_ready returns.
`timescale 1ns / 1ps
module priority_ready_queue_top
    import prq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  prq_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output prq_out_t out_data
);

    // Commands flow from the controller to the slot array, status flows back.
    prq_cmd_t  cmd;
    prq_stat_t stat;

    prq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (in_data.func),
        .stat      (stat),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The array keeps entries ordered by priority, oldest first among equals.
    prq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_data (in_data),
        .stat    (stat)
    );

endmodule
